/* hdl/bcf_pkg.sv */
package bcf_pkg;

    // Field and datapath widths of the sample, coefficient and accumulator formats
    localparam int SAMPLE_WIDTH       = 16;
    localparam int COEF_WIDTH         = 24;
    localparam int COEF_FRAC          = COEF_WIDTH - 4;
    localparam int ACC_WIDTH          = 32;
    localparam int PROD_WIDTH         = COEF_WIDTH + ACC_WIDTH;
    localparam int ACTIVE_WIDTH       = 4;
    localparam int SELECT_WIDTH       = 3;
    localparam int SLOT_WIDTH         = 3;

    // Store geometry
    localparam int COEFS_PER_SECTION  = 5;
    localparam int DELAYS_PER_SECTION = 2;
    localparam int DELAY_ROW_WIDTH    = DELAYS_PER_SECTION * ACC_WIDTH;

    // Sequencer schedule: five coefficient reads and one spare step per section
    localparam int STEPS_PER_SECTION  = 6;
    localparam int STEP_WIDTH         = 3;
    localparam int LAST_ISSUE_STEP    = 4;

    typedef enum logic {
        OP_FILTER = 1'b0,
        OP_COEF   = 1'b1
    } t_op;

    typedef enum logic [SLOT_WIDTH-1:0] {
        SLOT_B0 = 3'd0,
        SLOT_B1 = 3'd1,
        SLOT_B2 = 3'd2,
        SLOT_A1 = 3'd3,
        SLOT_A2 = 3'd4
    } t_slot;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_DONE
    } t_seq_state;

    typedef struct packed {
        t_op                            operation;
        logic signed [SAMPLE_WIDTH-1:0] sample_in;
        logic [SELECT_WIDTH-1:0]        section_select;
        logic [SLOT_WIDTH-1:0]          coefficient_slot;
        logic signed [COEF_WIDTH-1:0]   coefficient_value;
    } t_in_beat;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample_out;
        logic                           clipped;
    } t_out_beat;

    typedef struct packed {
        logic signed [ACC_WIDTH-1:0] w1;
        logic signed [ACC_WIDTH-1:0] w2;
    } t_delay_row;

    // One coefficient read issued by the sequencer
    typedef struct packed {
        logic  vld;
        logic  rd_delay;
        logic  last;
        t_slot slot;
    } t_issue;

endpackage

/* hdl/bcf_ram.sv */
module bcf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/bcf_seq.sv */
module bcf_seq #(
    parameter int MAX_SECTIONS = 8,
    localparam int SEC_W       = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [bcf_pkg::ACTIVE_WIDTH-1:0]   i_active,
    input  logic                               i_done,
    input  logic                               i_out_free,
    output bcf_pkg::t_issue                    o_iss,
    output logic [SEC_W-1:0]                   o_sec,
    output logic                               o_load,
    output logic                               o_busy
);

    localparam int CNT_BITS = $clog2(MAX_SECTIONS + 1);
    localparam int CMP_W    = (CNT_BITS > bcf_pkg::ACTIVE_WIDTH) ? CNT_BITS
                                                                  : bcf_pkg::ACTIVE_WIDTH;

    bcf_pkg::t_seq_state                 r_state, n_state;
    logic [SEC_W-1:0]                    r_sec, n_sec;
    logic [SEC_W-1:0]                    r_last_sec, n_last_sec;
    logic [bcf_pkg::STEP_WIDTH-1:0]      r_step, n_step;
    logic [CMP_W-1:0]                    act_ext;
    logic [CMP_W-1:0]                    used;
    logic                                sec_last;

    // Clamp the section count to what the store holds
    assign act_ext  = CMP_W'(i_active);
    assign used     = (act_ext > CMP_W'(MAX_SECTIONS)) ? CMP_W'(MAX_SECTIONS) : act_ext;
    assign sec_last = (r_sec == r_last_sec);

    always_comb begin
        n_state = r_state;
        case (r_state)
            bcf_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_state = (used == '0) ? bcf_pkg::ST_DONE : bcf_pkg::ST_ISSUE;
                end
            end
            bcf_pkg::ST_ISSUE: begin
                if (r_step == bcf_pkg::STEP_WIDTH'(bcf_pkg::LAST_ISSUE_STEP) && sec_last) begin
                    n_state = bcf_pkg::ST_DRAIN;
                end
            end
            bcf_pkg::ST_DRAIN: begin
                if (i_done) begin
                    n_state = bcf_pkg::ST_DONE;
                end
            end
            bcf_pkg::ST_DONE: begin
                if (i_out_free) begin
                    n_state = bcf_pkg::ST_IDLE;
                end
            end
            default: n_state = bcf_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        n_sec      = r_sec;
        n_step     = r_step;
        n_last_sec = r_last_sec;
        if (r_state == bcf_pkg::ST_IDLE && i_start) begin
            n_sec      = '0;
            n_step     = '0;
            n_last_sec = SEC_W'(used - CMP_W'(1));
        end else if (r_state == bcf_pkg::ST_ISSUE) begin
            if (r_step == bcf_pkg::STEP_WIDTH'(bcf_pkg::STEPS_PER_SECTION - 1)) begin
                n_step = '0;
                n_sec  = r_sec + SEC_W'(1);
            end else begin
                n_step = r_step + bcf_pkg::STEP_WIDTH'(1);
            end
        end
    end

    always_comb begin
        o_iss  = '0;
        o_load = 1'b0;
        o_busy = 1'b1;
        case (r_state)
            bcf_pkg::ST_IDLE: begin
                o_busy = 1'b0;
            end
            bcf_pkg::ST_ISSUE: begin
                o_iss.vld      = 1'b1;
                o_iss.rd_delay = (r_step == '0);
                o_iss.last     = sec_last;
                // Feedback products first so w0 is ready for b0
                case (r_step)
                    3'd0:    o_iss.slot = bcf_pkg::SLOT_A1;
                    3'd1:    o_iss.slot = bcf_pkg::SLOT_A2;
                    3'd2:    o_iss.slot = bcf_pkg::SLOT_B1;
                    3'd3:    o_iss.slot = bcf_pkg::SLOT_B2;
                    3'd4:    o_iss.slot = bcf_pkg::SLOT_B0;
                    default: o_iss.vld  = 1'b0;
                endcase
            end
            bcf_pkg::ST_DRAIN: begin
                o_busy = 1'b1;
            end
            bcf_pkg::ST_DONE: begin
                o_load = i_out_free;
            end
            default: o_busy = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= bcf_pkg::ST_IDLE;
            r_sec      <= '0;
            r_step     <= '0;
            r_last_sec <= '0;
        end else begin
            r_state    <= n_state;
            r_sec      <= n_sec;
            r_step     <= n_step;
            r_last_sec <= n_last_sec;
        end
    end

    assign o_sec = r_sec;

`ifndef SYNTH
    a_issue_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bcf_pkg::ST_ISSUE) |->
            (r_sec <= r_last_sec &&
             r_step < bcf_pkg::STEP_WIDTH'(bcf_pkg::STEPS_PER_SECTION)))
        else $error("sequencer section or step out of range");
`endif

endmodule

/* hdl/bcf_dp.sv */
module bcf_dp #(
    parameter int SEC_W = 3
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_start,
    input  logic signed [bcf_pkg::SAMPLE_WIDTH-1:0]   i_sample,
    input  bcf_pkg::t_issue                           i_iss,
    input  logic [SEC_W-1:0]                          i_sec,
    input  logic signed [bcf_pkg::COEF_WIDTH-1:0]     i_coef,
    input  bcf_pkg::t_delay_row                       i_drow,
    output logic                                      o_dwe,
    output logic [SEC_W-1:0]                          o_dwaddr,
    output bcf_pkg::t_delay_row                       o_dwdata,
    output logic                                      o_done,
    output bcf_pkg::t_out_beat                        o_result
);

    localparam int AW  = bcf_pkg::ACC_WIDTH;
    localparam int PW  = bcf_pkg::PROD_WIDTH;
    localparam int SW  = bcf_pkg::SAMPLE_WIDTH;
    localparam int SHW = PW + 1 - bcf_pkg::COEF_FRAC;
    localparam logic [PW:0]   HALF    = (PW + 1)'(1) << (bcf_pkg::COEF_FRAC - 1);
    localparam logic [AW-1:0] ACC_MAX = {1'b0, {(AW - 1){1'b1}}};
    localparam logic [AW-1:0] ACC_MIN = {1'b1, {(AW - 1){1'b0}}};
    localparam logic [SW-1:0] OUT_MAX = {1'b0, {(SW - 1){1'b1}}};
    localparam logic [SW-1:0] OUT_MIN = {1'b1, {(SW - 1){1'b0}}};

    // Multiply stage tags
    logic                        r_m_vld, r_m_last;
    bcf_pkg::t_slot              r_m_slot;
    logic [SEC_W-1:0]            r_m_sec;
    // Round stage
    logic                        r_r_vld, r_r_last;
    bcf_pkg::t_slot              r_r_slot;
    logic signed [PW-1:0]        r_prod;
    // Accumulate stage
    logic                        r_a_vld, r_a_last;
    bcf_pkg::t_slot              r_a_slot;
    logic [AW-1:0]               r_p;
    logic                        r_p_ovf;
    // Final add of b2 product
    logic                        r_f_vld, r_f_last;
    logic                        r_done;
    logic                        r_clip;

    logic signed [AW-1:0]        r_x, r_acc, r_w0, r_pb1, r_pb2;
    logic signed [AW-1:0]        operand;
    logic [PW:0]                 rsum;
    logic [SHW-1:0]              rsh;
    logic                        rnd_ovf;
    logic [AW-1:0]               p_sat;
    logic [AW-1:0]               add_a, add_b;
    logic                        add_sub, add_use;
    logic [AW:0]                 add_s;
    logic                        add_ovf;
    logic [AW-1:0]               add_sat;
    logic                        out_ovf;

    always_comb begin
        case (r_m_slot)
            bcf_pkg::SLOT_A1, bcf_pkg::SLOT_B1: operand = i_drow.w1;
            bcf_pkg::SLOT_A2, bcf_pkg::SLOT_B2: operand = i_drow.w2;
            bcf_pkg::SLOT_B0:                   operand = r_w0;
            default:                            operand = '0;
        endcase
    end

    // Round half up, floor shift, saturate to the internal width
    assign rsum    = {r_prod[PW-1], r_prod} + HALF;
    assign rsh     = rsum[PW:bcf_pkg::COEF_FRAC];
    assign rnd_ovf = !((&rsh[SHW-1:AW-1]) || !(|rsh[SHW-1:AW-1]));
    assign p_sat   = rnd_ovf ? (rsh[SHW-1] ? ACC_MIN : ACC_MAX) : rsh[AW-1:0];

    // One shared saturating adder; final add and slot adds never coincide
    always_comb begin
        add_a   = r_p;
        add_b   = r_pb1;
        add_sub = 1'b0;
        add_use = 1'b0;
        if (r_f_vld) begin
            add_a   = r_acc;
            add_b   = r_pb2;
            add_use = 1'b1;
        end else if (r_a_vld) begin
            case (r_a_slot)
                bcf_pkg::SLOT_A1: begin
                    add_a   = r_x;
                    add_sub = 1'b1;
                    add_use = 1'b1;
                end
                bcf_pkg::SLOT_A2: begin
                    add_a   = r_acc;
                    add_sub = 1'b1;
                    add_use = 1'b1;
                end
                bcf_pkg::SLOT_B0: begin
                    add_use = 1'b1;
                end
                default: add_use = 1'b0;
            endcase
            if (add_sub) begin
                add_b = r_p;
            end
        end
    end

    assign add_s   = add_sub ? ({add_a[AW-1], add_a} - {add_b[AW-1], add_b})
                             : ({add_a[AW-1], add_a} + {add_b[AW-1], add_b});
    assign add_ovf = add_s[AW] ^ add_s[AW-1];
    assign add_sat = add_ovf ? (add_s[AW] ? ACC_MIN : ACC_MAX) : add_s[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld  <= 1'b0;
            r_r_vld  <= 1'b0;
            r_a_vld  <= 1'b0;
            r_f_vld  <= 1'b0;
            r_done   <= 1'b0;
            r_clip   <= 1'b0;
        end else begin
            r_m_vld  <= i_iss.vld;
            r_r_vld  <= r_m_vld;
            r_a_vld  <= r_r_vld;
            r_f_vld  <= r_a_vld && (r_a_slot == bcf_pkg::SLOT_B0);
            r_done   <= r_f_vld && r_f_last;
            if (i_start) begin
                r_clip <= 1'b0;
            end else begin
                r_clip <= r_clip | (r_a_vld & r_p_ovf) | (add_use & add_ovf);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_slot <= i_iss.slot;
        r_m_last <= i_iss.last;
        r_m_sec  <= i_sec;
        r_r_slot <= r_m_slot;
        r_r_last <= r_m_last;
        r_prod   <= PW'(i_coef) * PW'(operand);
        r_a_slot <= r_r_slot;
        r_a_last <= r_r_last;
        r_p      <= p_sat;
        r_p_ovf  <= rnd_ovf;
        r_f_last <= r_a_last;
        if (i_start) begin
            r_x <= AW'(i_sample);
        end else if (r_f_vld) begin
            r_x <= add_sat;
        end
        if (r_a_vld && !r_f_vld) begin
            case (r_a_slot)
                bcf_pkg::SLOT_A1: r_acc <= add_sat;
                bcf_pkg::SLOT_A2: r_w0  <= add_sat;
                bcf_pkg::SLOT_B1: r_pb1 <= r_p;
                bcf_pkg::SLOT_B2: r_pb2 <= r_p;
                bcf_pkg::SLOT_B0: r_acc <= add_sat;
                default:          r_acc <= r_acc;
            endcase
        end
    end

    // Shift delays when b0 is multiplied: w1 <- w0, w2 <- old w1
    assign o_dwe       = r_m_vld && (r_m_slot == bcf_pkg::SLOT_B0);
    assign o_dwaddr    = r_m_sec;
    assign o_dwdata.w1 = r_w0;
    assign o_dwdata.w2 = i_drow.w1;

    assign out_ovf             = !((&r_x[AW-1:SW-1]) || !(|r_x[AW-1:SW-1]));
    assign o_result.sample_out = out_ovf ? (r_x[AW-1] ? OUT_MIN : OUT_MAX) : r_x[SW-1:0];
    assign o_result.clipped    = r_clip | out_ovf;
    assign o_done              = r_done;

`ifndef SYNTH
    a_adder_no_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_f_vld |-> !(r_a_vld && (r_a_slot == bcf_pkg::SLOT_A1 ||
                                  r_a_slot == bcf_pkg::SLOT_A2 ||
                                  r_a_slot == bcf_pkg::SLOT_B0)))
        else $error("final add collides with a section add");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("done held for more than one cycle");
`endif

endmodule

/* hdl/biquad_cascade_iir_filter.sv */
// Cascade of up to MAX_SECTIONS direct form II biquads, fixed point.
//
// Input channel (i_in_valid / o_in_stall / i_in_data): a beat either filters
// one Q1.15 sample or writes one Q4.20 coefficient (b0, b1, b2, a1, a2) of one
// section. A coefficient beat gives no result.
// Output channel (o_out_valid / i_out_stall / o_out_data): one beat for every
// sample, saturated to 16 bits, with a flag set when any product, sum or the
// output clipped.
// Config channel (i_cfg_valid / o_cfg_ready / i_cfg_data): number of sections
// in use; always ready; write only while the block is idle.
//
// One multiplier, fed from the coefficient RAM one read per cycle, does five
// products per section, followed by a spare step; the next sample is taken
// once the result sits in the output register.
// Reset clears valid bits on both stores so that all coefficients and delays
// read as zero until written, and sets the section count to 1; no clearing
// sweep runs. A stalled result holds in the output register; the sequencer
// then waits with the next result and keeps o_in_stall high.
module biquad_cascade_iir_filter #(
    parameter int MAX_SECTIONS = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  bcf_pkg::t_in_beat                  i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output bcf_pkg::t_out_beat                 o_out_data,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [bcf_pkg::ACTIVE_WIDTH-1:0]   i_cfg_data
);

    localparam int SEC_W     = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
    localparam int NUM_COEFS = MAX_SECTIONS * bcf_pkg::COEFS_PER_SECTION;
    localparam int CA_W      = (NUM_COEFS > 1) ? $clog2(NUM_COEFS) : 1;

    logic [bcf_pkg::ACTIVE_WIDTH-1:0]        r_active;
    logic [NUM_COEFS-1:0]                    r_cvld;
    logic [MAX_SECTIONS-1:0]                 r_dvld;
    logic                                    r_cv_q, r_dv_q;
    logic                                    r_out_vld;
    bcf_pkg::t_out_beat                      r_out_data;

    logic                                    in_acc, start, busy;
    logic                                    cwe;
    logic [CA_W-1:0]                         cwaddr, craddr;
    logic [bcf_pkg::COEF_WIDTH-1:0]          cq;
    logic signed [bcf_pkg::COEF_WIDTH-1:0]   coef;
    logic [bcf_pkg::DELAY_ROW_WIDTH-1:0]     dq;
    bcf_pkg::t_delay_row                     drow;
    bcf_pkg::t_issue                         iss;
    logic [SEC_W-1:0]                        sec;
    logic                                    dwe;
    logic [SEC_W-1:0]                        dwaddr;
    bcf_pkg::t_delay_row                     dwdata;
    logic                                    done, load, out_free;
    bcf_pkg::t_out_beat                      result;

    assign o_in_stall = busy;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign start      = in_acc && (i_in_data.operation == bcf_pkg::OP_FILTER);

    // Drop coefficient writes to sections or slots that do not exist
    assign cwe    = in_acc && (i_in_data.operation == bcf_pkg::OP_COEF) &&
                    (int'(i_in_data.section_select) < MAX_SECTIONS) &&
                    (int'(i_in_data.coefficient_slot) < bcf_pkg::COEFS_PER_SECTION);
    assign cwaddr = CA_W'(int'(i_in_data.section_select) * bcf_pkg::COEFS_PER_SECTION +
                          int'(i_in_data.coefficient_slot));
    assign craddr = CA_W'(int'(sec) * bcf_pkg::COEFS_PER_SECTION + int'(iss.slot));

    bcf_ram #(
        .WIDTH (bcf_pkg::COEF_WIDTH),
        .DEPTH (NUM_COEFS)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (cwe),
        .i_waddr (cwaddr),
        .i_wdata (i_in_data.coefficient_value),
        .i_re    (iss.vld),
        .i_raddr (craddr),
        .o_rdata (cq)
    );

    bcf_ram #(
        .WIDTH (bcf_pkg::DELAY_ROW_WIDTH),
        .DEPTH (MAX_SECTIONS)
    ) u_delay_ram (
        .i_clk   (i_clk),
        .i_we    (dwe),
        .i_waddr (dwaddr),
        .i_wdata (dwdata),
        .i_re    (iss.rd_delay),
        .i_raddr (sec),
        .o_rdata (dq)
    );

    // Entries never written since reset read as zero
    assign coef = r_cv_q ? $signed(cq) : '0;
    assign drow = r_dv_q ? bcf_pkg::t_delay_row'(dq) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= bcf_pkg::ACTIVE_WIDTH'(1);
            r_cvld    <= '0;
            r_dvld    <= '0;
            r_cv_q    <= 1'b0;
            r_dv_q    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_active <= i_cfg_data;
            end
            if (cwe) begin
                r_cvld[cwaddr] <= 1'b1;
            end
            if (dwe) begin
                r_dvld[dwaddr] <= 1'b1;
            end
            if (iss.vld) begin
                r_cv_q <= r_cvld[craddr];
            end
            if (iss.rd_delay) begin
                r_dv_q <= r_dvld[sec];
            end
            // Advance the output register: load a new beat or drop a taken one
            if (load) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_data <= result;
        end
    end

    assign out_free = !r_out_vld || !i_out_stall;

    bcf_seq #(
        .MAX_SECTIONS (MAX_SECTIONS)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_active   (r_active),
        .i_done     (done),
        .i_out_free (out_free),
        .o_iss      (iss),
        .o_sec      (sec),
        .o_load     (load),
        .o_busy     (busy)
    );

    bcf_dp #(
        .SEC_W (SEC_W)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_sample (i_in_data.sample_in),
        .i_iss    (iss),
        .i_sec    (sec),
        .i_coef   (coef),
        .i_drow   (drow),
        .o_dwe    (dwe),
        .o_dwaddr (dwaddr),
        .o_dwdata (dwdata),
        .o_done   (done),
        .o_result (result)
    );

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out_data;
    assign o_cfg_ready = 1'b1;

`ifndef SYNTH
    a_coef_rw_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cwe && iss.vld))
        else $error("coefficient write during a filter run");
    a_delay_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dwe |-> o_in_stall)
        else $error("delay write-back while idle");
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> (!r_out_vld || !i_out_stall))
        else $error("result loaded over a stalled beat");
`endif

endmodule
